// ===== rtl/libl_pkg.sv =====
// Shared types and constants for the line index builder and lookup unit.
// Depends on nothing; imported by line_index_builder_and_lookup_unit.
`default_nettype none

package libl_pkg;

	// Default sizes of the line table and of a byte offset.
	localparam int unsigned DEF_MAX_LINES   = 1024;
	localparam int unsigned DEF_OFFSET_BITS = 20;

	// Command codes on the op port.
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Result kinds and status codes.
	localparam logic       KIND_END   = 1'b0;
	localparam logic       KIND_QUERY = 1'b1;
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_OVF   = 2'd2;

	// Line break characters.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// First half of a possible two-byte break.
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_CR   = 2'd1,
		PEND_LF   = 2'd2
	} pend_t;

	// Lookup sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_CHECK   = 2'd1,
		ST_COMPARE = 2'd2,
		ST_FINISH  = 2'd3
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/line_index_builder_and_lookup_unit.sv =====
// Line index builder and offset-to-line lookup, top level.
// Depends on libl_pkg for command codes, status codes and state types.
`default_nettype none

//  Channel   Direction  Handshake              Payload
//  command   in         start, busy            op, data_byte, query_offset
//  result    out        done (one-cycle pulse) answer_kind, line_number, found_start,
//                                              found_length, total_lines, status
//
// A source byte leaves busy low, so the next transfer may follow at once.
// The report of an end command appears on the following cycle.
// A query walks the line table by binary search, each halving step being one memory
// read and one compare through the single read port of the line table. Out-of-range
// queries and queries on an empty table answer on the next cycle. Reset clears all
// control state; the line table is not cleared because only entries below the line
// count are ever read. The result side cannot stall, so every result is a single-cycle
// pulse on done.
module line_index_builder_and_lookup_unit #(
	parameter int unsigned MAX_LINES   = libl_pkg::DEF_MAX_LINES,
	parameter int unsigned OFFSET_BITS = libl_pkg::DEF_OFFSET_BITS,
	parameter int unsigned LINE_BITS   = $clog2(MAX_LINES),
	parameter int unsigned CNT_BITS    = $clog2(MAX_LINES + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             op,
	input  wire logic [7:0]             data_byte,
	input  wire logic [OFFSET_BITS-1:0] query_offset,
	output logic                        done,
	output logic                        answer_kind,
	output logic [LINE_BITS-1:0]        line_number,
	output logic [OFFSET_BITS-1:0]      found_start,
	output logic [OFFSET_BITS-1:0]      found_length,
	output logic [CNT_BITS-1:0]         total_lines,
	output logic [1:0]                  status
);

	import libl_pkg::*;

	localparam int unsigned OB = OFFSET_BITS;

	// Control state.
	state_t              state_q, state_nx;
	pend_t               pend_q;
	logic [CNT_BITS-1:0] lines_q;
	logic [OB:0]         bp_q;     // bytes taken so far, which is the buffer size
	logic [OB:0]         cls_q;    // start of the line now being read
	logic                ovf_q;
	logic                done_q;

	// Search and result registers.
	logic [CNT_BITS-1:0]  lo_q, hi_q, mid_q;
	logic [OB-1:0]        qoff_q;
	logic                 kind_q;
	logic [LINE_BITS-1:0] line_q;
	logic [OB-1:0]        fstart_q, flen_q;
	logic [CNT_BITS-1:0]  total_q;
	logic [1:0]           status_q;

	// Line table: each entry holds the start offset above the length.
	logic [2*OB-1:0]      mem [MAX_LINES];
	logic [2*OB-1:0]      rd_data_q;
	logic                 rd_en;
	logic [LINE_BITS-1:0] rd_addr;
	logic                 wr_en;
	logic [2*OB-1:0]      wr_data;

	logic                accept, byte_take, is_brk, is_pair, rec_req, tbl_full, ovf_nx;
	logic [OB:0]         bp_inc, rec_len;
	logic [CNT_BITS-1:0] diff, mid_nx;
	logic                step_more;
	logic [OB-1:0]       rd_start;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Break detection. Pairs are matched greedily: the second byte of a pair only moves
	// the line start past itself and never opens a new break.
	assign byte_take = accept && (op == OP_BYTE) && !bp_q[OB];
	assign is_brk    = (data_byte == CH_CR) || (data_byte == CH_LF);
	assign is_pair   = ((pend_q == PEND_CR) && (data_byte == CH_LF)) ||
	                   ((pend_q == PEND_LF) && (data_byte == CH_CR));
	assign bp_inc    = bp_q + 1'b1;

	// A line closes on a break byte, or on an end command that has bytes after the last
	// break. In both cases the line ends at the current byte position.
	assign rec_req  = (byte_take && !is_pair && is_brk) ||
	                  (accept && (op == OP_END) && (bp_q > cls_q));
	assign rec_len  = bp_q - cls_q;
	assign tbl_full = (lines_q >= CNT_BITS'(MAX_LINES));
	assign wr_en    = rec_req && !tbl_full;
	assign wr_data  = {cls_q[OB-1:0], rec_len[OB-1:0]};
	assign ovf_nx   = ovf_q || (rec_req && tbl_full);

	// Search step: the window [lo, hi) narrows until one line is left.
	assign diff      = hi_q - lo_q;
	assign mid_nx    = lo_q + (diff >> 1);
	assign step_more = (diff > CNT_BITS'(1));
	assign rd_start  = rd_data_q[2*OB-1:OB];

	always_comb begin
		state_nx = state_q;
		rd_en    = 1'b0;
		rd_addr  = lo_q[LINE_BITS-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_QUERY) && ({1'b0, query_offset} <= bp_q) &&
				    (lines_q != '0)) begin
					state_nx = ST_CHECK;
				end
			end
			ST_CHECK: begin
				rd_en = 1'b1;
				if (step_more) begin
					rd_addr  = mid_nx[LINE_BITS-1:0];
					state_nx = ST_COMPARE;
				end else begin
					state_nx = ST_FINISH;
				end
			end
			ST_COMPARE: begin
				state_nx = ST_CHECK;
			end
			ST_FINISH: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= PEND_NONE;
			lines_q <= '0;
			bp_q    <= '0;
			cls_q   <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			ovf_q   <= ovf_nx;
			done_q  <= 1'b0;
			if (wr_en) begin
				lines_q <= lines_q + 1'b1;
			end
			if (byte_take) begin
				bp_q <= bp_inc;
				if (is_pair) begin
					pend_q <= PEND_NONE;
					cls_q  <= bp_inc;
				end else if (is_brk) begin
					cls_q  <= bp_inc;
					pend_q <= (data_byte == CH_CR) ? PEND_CR : PEND_LF;
				end else begin
					pend_q <= PEND_NONE;
				end
			end
			if (accept && (op == OP_END)) begin
				pend_q <= PEND_NONE;
				cls_q  <= bp_q;
				done_q <= 1'b1;
			end
			if (accept && (op == OP_QUERY) &&
			    (({1'b0, query_offset} > bp_q) || (lines_q == '0))) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_FINISH) begin
				done_q <= 1'b1;
			end
		end
	end

	// Search window and result payload.
	always_ff @(posedge clk) begin
		if (accept && (op == OP_END)) begin
			kind_q   <= KIND_END;
			line_q   <= '0;
			fstart_q <= '0;
			flen_q   <= '0;
			total_q  <= wr_en ? (lines_q + 1'b1) : lines_q;
			status_q <= ovf_nx ? STAT_OVF : STAT_OK;
		end
		if (accept && (op == OP_QUERY)) begin
			kind_q   <= KIND_QUERY;
			line_q   <= '0;
			fstart_q <= '0;
			flen_q   <= '0;
			total_q  <= lines_q;
			qoff_q   <= query_offset;
			lo_q     <= '0;
			hi_q     <= lines_q;
			if ({1'b0, query_offset} > bp_q) begin
				status_q <= STAT_RANGE;
			end else begin
				status_q <= ovf_q ? STAT_OVF : STAT_OK;
			end
		end
		if (state_q == ST_CHECK) begin
			mid_q <= mid_nx;
		end
		if (state_q == ST_COMPARE) begin
			if (rd_start <= qoff_q) begin
				lo_q <= mid_q;
			end else begin
				hi_q <= mid_q;
			end
		end
		if (state_q == ST_FINISH) begin
			line_q   <= lo_q[LINE_BITS-1:0];
			fstart_q <= rd_start;
			flen_q   <= rd_data_q[OB-1:0];
		end
	end

	// Line table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[lines_q[LINE_BITS-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign done         = done_q;
	assign answer_kind  = kind_q;
	assign line_number  = line_q;
	assign found_start  = fstart_q;
	assign found_length = flen_q;
	assign total_lines  = total_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	// The line count never runs past the table.
	a_lines_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lines_q <= CNT_BITS'(MAX_LINES))
		else $error("line count exceeds table size");

	// The open line never starts beyond the buffer end.
	a_cls_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cls_q <= bp_q)
		else $error("line start past buffer end");

	// The search window is never empty while the search runs.
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK || state_q == ST_COMPARE) |-> (lo_q < hi_q))
		else $error("search window collapsed");

	// A result follows only an end or query transfer, or the last search read.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) || !done_q || $past(state_q == ST_FINISH ||
		(start && !busy && (op == OP_END || op == OP_QUERY))))
		else $error("result without a cause");

	// The table is never written while a lookup is reading it.
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("table write during lookup");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_line_index_builder_and_lookup_unit.sv =====
// Self-checking testbench for line_index_builder_and_lookup_unit.
// Depends on libl_pkg and the unit itself; it predicts line tables, lookups and end
// reports in its own scoreboard and checks every result the unit emits.
module tb_line_index_builder_and_lookup_unit;
	import libl_pkg::*;

	localparam int unsigned CLK_PERIOD      = 8;
	localparam int unsigned TABLE_DEPTH     = DEF_MAX_LINES;
	localparam int unsigned OFS_W           = DEF_OFFSET_BITS;
	localparam int unsigned LINE_W          = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W           = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned BUFFER_CAP      = 1 << OFS_W;
	localparam int unsigned DIRECTED_CMDS   = 25;
	localparam int unsigned RANDOM_CMDS     = 250;
	// Quiet spell at the end, long enough for a lookup over a full table to finish.
	localparam int unsigned SETTLE_CYCLES   = 40;
	// About 1400 commands, each with its random gap and a full-table lookup,
	// finish far below this.
	localparam int unsigned WATCHDOG_CYCLES = 400_000;
	// The op code the unit must ignore.
	localparam logic [1:0]  OP_SPARE        = 2'd3;
	localparam logic [7:0]  CH_FILL         = 8'h2E;

	// How the sender paces a command: random gaps, back to back, or only once all
	// outstanding answers have come back.
	typedef enum {PACE_SPREAD, PACE_BURST, PACE_DRAIN} pace_t;
	typedef enum {BRK_CR, BRK_LF, BRK_CRLF, BRK_LFCR} brk_style_t;

	typedef struct {
		logic [1:0]       op;
		logic [7:0]       data_byte;
		logic [OFS_W-1:0] query_offset;
		int unsigned      gap;
		bit               drain;
	} index_cmd_t;

	typedef struct packed {
		logic              answer_kind;
		logic [LINE_W-1:0] line_number;
		logic [OFS_W-1:0]  found_start;
		logic [OFS_W-1:0]  found_length;
		logic [CNT_W-1:0]  total_lines;
		logic [1:0]        status;
	} line_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = OP_BYTE;
	logic [7:0] data_byte = '0;
	logic [OFS_W-1:0] query_offset = '0;
	logic busy;
	logic done;
	logic answer_kind;
	logic [LINE_W-1:0] line_number;
	logic [OFS_W-1:0] found_start;
	logic [OFS_W-1:0] found_length;
	logic [CNT_W-1:0] total_lines;
	logic [1:0] status;

	line_index_builder_and_lookup_unit #(
		.MAX_LINES  (TABLE_DEPTH),
		.OFFSET_BITS(OFS_W)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.data_byte   (data_byte),
		.query_offset(query_offset),
		.done        (done),
		.answer_kind (answer_kind),
		.line_number (line_number),
		.found_start (found_start),
		.found_length(found_length),
		.total_lines (total_lines),
		.status      (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Reset is released at a falling edge, once only.
	initial begin : reset_gen
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predicted state of the unit: the kept line table, the byte count, the start
	// of the line still being read, the first half of a possible two-byte break
	// and the sticky overflow flag.
	// ------------------------------------------------------------------
	logic [OFS_W-1:0] kept_start  [TABLE_DEPTH];
	logic [OFS_W-1:0] kept_length [TABLE_DEPTH];
	int unsigned      kept_lines = 0;
	logic [OFS_W:0]   bytes_seen = '0;
	logic [OFS_W:0]   open_line_start = '0;
	pend_t            half_break = PEND_NONE;
	bit               table_overflowed = 1'b0;

	line_answer_t     awaited_answers[$];
	index_cmd_t       pending_cmds[$];

	int unsigned bytes_taken = 0;
	int unsigned ends_taken = 0;
	int unsigned lookups = 0;
	int unsigned beyond = 0;
	int unsigned spare_ops = 0;
	int unsigned answers_checked = 0;
	int unsigned mismatch_count = 0;

	// A break closes the open line. Once the table is full, the line is lost and
	// the overflow flag stays set for the rest of the run.
	function automatic void close_line(input logic [OFS_W:0] end_at);
		logic [OFS_W:0] span;
		span = end_at - open_line_start;
		if (kept_lines >= TABLE_DEPTH) begin
			table_overflowed = 1'b1;
		end else begin
			kept_start[kept_lines]  = open_line_start[OFS_W-1:0];
			kept_length[kept_lines] = span[OFS_W-1:0];
			kept_lines++;
		end
	endfunction

	// Pairs are matched greedily: a CR right after a lone LF (or an LF right after
	// a lone CR) only moves the start of the next line past itself.
	function automatic void take_source_byte(input logic [7:0] b);
		logic [OFS_W:0] at;
		at = bytes_seen;
		// The buffer holds 2^OFS_W bytes; anything after that is dropped.
		if (at[OFS_W])
			return;
		bytes_seen = at + 1'b1;
		if (half_break != PEND_NONE) begin
			if ((half_break == PEND_CR && b == CH_LF) ||
			    (half_break == PEND_LF && b == CH_CR)) begin
				half_break = PEND_NONE;
				open_line_start = at + 1'b1;
				return;
			end
			half_break = PEND_NONE;
		end
		if (b == CH_CR || b == CH_LF) begin
			close_line(at);
			open_line_start = at + 1'b1;
			half_break = (b == CH_CR) ? PEND_CR : PEND_LF;
		end
	endfunction

	// Applies one accepted command and queues the answer it must produce, if any.
	function automatic void step_line_index(input logic [1:0] cmd_op, input logic [7:0] b,
			input logic [OFS_W-1:0] q);
		line_answer_t ans;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		ans = '0;
		case (cmd_op)
		OP_BYTE: begin
			take_source_byte(b);
			bytes_taken++;
			return;
		end
		OP_END: begin
			// A final line without a break is kept; a trailing break adds nothing.
			if (bytes_seen > open_line_start) begin
				close_line(bytes_seen);
				open_line_start = bytes_seen;
			end
			half_break = PEND_NONE;
			ans.answer_kind = KIND_END;
			ans.status = table_overflowed ? STAT_OVF : STAT_OK;
			ends_taken++;
		end
		OP_QUERY: begin
			ans.answer_kind = KIND_QUERY;
			lookups++;
			// The offset equal to the byte count is still a valid position.
			if ({1'b0, q} > bytes_seen) begin
				ans.status = STAT_RANGE;
				beyond++;
			end else begin
				// Last kept line that starts at or before the offset; an empty
				// table answers line 0 with zero start and length.
				if (kept_lines > 0) begin
					lo = 0;
					hi = kept_lines;
					while (hi - lo > 1) begin
						mid = lo + ((hi - lo) >> 1);
						if (kept_start[mid] <= q)
							lo = mid;
						else
							hi = mid;
					end
					ans.line_number  = lo[LINE_W-1:0];
					ans.found_start  = kept_start[lo];
					ans.found_length = kept_length[lo];
				end
				ans.status = table_overflowed ? STAT_OVF : STAT_OK;
			end
		end
		default: begin
			spare_ops++;
			return;
		end
		endcase
		ans.total_lines = kept_lines[CNT_W-1:0];
		awaited_answers = {awaited_answers, ans};
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Monitor: at each rising edge it first checks a result that is on the ports,
	// then records a command transfer and predicts its answer. A result can never
	// belong to a command accepted at the same edge, so this order is safe.
	// ------------------------------------------------------------------
	bit took_item = 1'b0;

	always @(posedge clk) begin
		line_answer_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("result with no command waiting on it, answer_kind",
						64'(answer_kind), 64'(0));
				end else begin
					want = awaited_answers.pop_front();
					answers_checked++;
					if (answer_kind !== want.answer_kind)
						report_mismatch("answer_kind", 64'(answer_kind),
							64'(want.answer_kind));
					if (line_number !== want.line_number)
						report_mismatch("line_number", 64'(line_number),
							64'(want.line_number));
					if (found_start !== want.found_start)
						report_mismatch("found_start", 64'(found_start),
							64'(want.found_start));
					if (found_length !== want.found_length)
						report_mismatch("found_length", 64'(found_length),
							64'(want.found_length));
					if (total_lines !== want.total_lines)
						report_mismatch("total_lines", 64'(total_lines),
							64'(want.total_lines));
					if (status !== want.status)
						report_mismatch("status", 64'(status), 64'(want.status));
				end
			end
			took_item = start && !busy;
			if (took_item)
				step_line_index(op, data_byte, query_offset);
		end
	end

	// ------------------------------------------------------------------
	// Driver: works at the falling edge. It retires the command that the last
	// rising edge took, fetches the next one, counts down its gap and then offers
	// it. A drain command is held back until no answer is outstanding. start is
	// assigned exactly once per edge, so a back-to-back transfer keeps it high.
	// While nothing is offered the payload ports carry random junk.
	// ------------------------------------------------------------------
	index_cmd_t  next_cmd;
	bit          holding = 1'b0;
	bit          offering = 1'b0;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (offering && took_item) begin
				offering = 1'b0;
				holding = 1'b0;
			end
			if (!holding && pending_cmds.size() > 0) begin
				next_cmd = pending_cmds.pop_front();
				holding = 1'b1;
				gap_left = next_cmd.gap;
			end
			if (holding && !offering) begin
				if (gap_left > 0)
					gap_left--;
				else if (!next_cmd.drain || awaited_answers.size() == 0)
					offering = 1'b1;
			end
		end
		start <= offering;
		if (offering) begin
			op <= next_cmd.op;
			data_byte <= next_cmd.data_byte;
			query_offset <= next_cmd.query_offset;
		end else begin
			op <= 2'($urandom);
			data_byte <= 8'($urandom);
			query_offset <= OFS_W'($urandom);
		end
	end

	// ------------------------------------------------------------------
	// Command generation. planned_bytes mirrors the byte count the unit will have
	// when each queued command arrives, so lookups can aim inside the buffer.
	// ------------------------------------------------------------------
	int unsigned planned_bytes = 0;
	int unsigned cmds_planned = 0;
	int unsigned calm_left = 0;

	task automatic queue_cmd(input logic [1:0] cmd_op, input logic [7:0] b,
			input logic [OFS_W-1:0] q, input pace_t mode);
		index_cmd_t c;
		// Keep the pending queue short so the driver never lags far behind.
		while (pending_cmds.size() > 256)
			@(negedge clk);
		c.op = cmd_op;
		c.data_byte = b;
		c.query_offset = q;
		c.gap = 0;
		if (mode != PACE_BURST) begin
			if (calm_left > 0) begin
				calm_left--;
			end else begin
				// Now and then a stretch of commands goes out with no idle cycles.
				if ($urandom_range(0, 30) == 0)
					calm_left = $urandom_range(8, 40);
				c.gap = $urandom_range(0, 10);
			end
		end
		c.drain = (mode == PACE_DRAIN) || (mode == PACE_SPREAD && $urandom_range(0, 79) == 0);
		pending_cmds = {pending_cmds, c};
		if (cmd_op == OP_BYTE && planned_bytes < BUFFER_CAP)
			planned_bytes++;
		cmds_planned++;
	endtask

	// Filler for payload fields that the command does not use.
	function automatic logic [7:0] junk_byte();
		return 8'($urandom);
	endfunction

	function automatic logic [OFS_W-1:0] junk_ofs();
		return OFS_W'($urandom);
	endfunction

	// Lookup offsets: mostly inside the buffer, some at its end, some just past it,
	// some anywhere in the field's range and some at zero.
	function automatic logic [OFS_W-1:0] pick_offset();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return OFS_W'($urandom_range(0, planned_bytes));
		else if (roll == 6)
			return OFS_W'(planned_bytes);
		else if (roll == 7)
			return OFS_W'(planned_bytes + $urandom_range(1, 3));
		else if (roll == 8)
			return OFS_W'($urandom);
		else
			return '0;
	endfunction

	initial begin : stimulus
		logic [7:0] opening_text [10] = '{8'h00, CH_CR, CH_LF, 8'hFF, CH_LF, CH_CR, CH_CR,
			CH_LF, CH_CR, 8'h7F};
		logic [OFS_W-1:0] opening_probes [6] = '{20'd9, 20'd10, 20'd11, 20'd0, 20'hFFFFF,
			20'd3};
		logic [7:0]  b;
		int unsigned roll;
		brk_style_t  style;

		// Directed part. On an empty buffer offset 0 is valid and answers line 0,
		// offset 1 is past the end, and an end report counts no lines.
		queue_cmd(OP_QUERY, junk_byte(), '0, PACE_SPREAD);
		queue_cmd(OP_QUERY, junk_byte(), 20'd1, PACE_SPREAD);
		queue_cmd(OP_END, junk_byte(), junk_ofs(), PACE_SPREAD);
		// CR LF and LF CR pairs, CR LF CR (a pair then a lone CR), extreme byte
		// values and an unfinished line at the end.
		foreach (opening_text[i])
			queue_cmd(OP_BYTE, opening_text[i], junk_ofs(), PACE_SPREAD);
		// Inside the unfinished line, at the buffer end, past it, at zero, with every
		// offset bit set, and in an ordinary line.
		foreach (opening_probes[i])
			queue_cmd(OP_QUERY, junk_byte(), opening_probes[i], PACE_SPREAD);
		// The end closes the unfinished line; a second end records nothing more.
		queue_cmd(OP_END, junk_byte(), junk_ofs(), PACE_SPREAD);
		queue_cmd(OP_END, junk_byte(), junk_ofs(), PACE_SPREAD);
		// Bytes after an end continue the same buffer; a lone break there closes an empty line.
		queue_cmd(OP_BYTE, CH_LF, junk_ofs(), PACE_SPREAD);
		queue_cmd(OP_END, junk_byte(), junk_ofs(), PACE_SPREAD);
		// The spare op code is ignored; the lookup after it waits for a quiet unit.
		queue_cmd(OP_SPARE, junk_byte(), junk_ofs(), PACE_DRAIN);
		queue_cmd(OP_QUERY, junk_byte(), 20'd10, PACE_DRAIN);

		// Random part: mostly short lines with every break style and lookups in
		// between, plus end reports, ignored op codes and loose runs of breaks.
		while (cmds_planned < DIRECTED_CMDS + RANDOM_CMDS) begin
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				repeat ($urandom_range(0, 6)) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_CR || b == CH_LF)
						b = CH_FILL;
					queue_cmd(OP_BYTE, b, junk_ofs(), PACE_SPREAD);
				end
				style = brk_style_t'($urandom_range(0, 3));
				case (style)
				BRK_CR: begin
					queue_cmd(OP_BYTE, CH_CR, junk_ofs(), PACE_SPREAD);
				end
				BRK_LF: begin
					queue_cmd(OP_BYTE, CH_LF, junk_ofs(), PACE_SPREAD);
				end
				BRK_CRLF: begin
					queue_cmd(OP_BYTE, CH_CR, junk_ofs(), PACE_SPREAD);
					queue_cmd(OP_BYTE, CH_LF, junk_ofs(), PACE_SPREAD);
				end
				default: begin
					queue_cmd(OP_BYTE, CH_LF, junk_ofs(), PACE_SPREAD);
					queue_cmd(OP_BYTE, CH_CR, junk_ofs(), PACE_SPREAD);
				end
				endcase
			end else if (roll < 85) begin
				queue_cmd(OP_QUERY, junk_byte(), pick_offset(), PACE_SPREAD);
			end else if (roll < 90) begin
				queue_cmd(OP_END, junk_byte(), junk_ofs(), PACE_SPREAD);
			end else if (roll < 93) begin
				queue_cmd(OP_SPARE, junk_byte(), junk_ofs(), PACE_SPREAD);
			end else begin
				repeat ($urandom_range(1, 4))
					queue_cmd(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, junk_ofs(),
						PACE_SPREAD);
			end
		end

		// Runs of lone LFs push the table past its capacity.
		for (int unsigned i = 0; i < 1100; i++) begin
			queue_cmd(OP_BYTE, ($urandom_range(0, 19) == 0) ? CH_FILL : CH_LF, junk_ofs(),
				PACE_SPREAD);
			if (i % 100 == 0)
				queue_cmd(OP_QUERY, junk_byte(), pick_offset(), PACE_SPREAD);
		end
		repeat (10)
			queue_cmd(OP_QUERY, junk_byte(), pick_offset(), PACE_SPREAD);
		queue_cmd(OP_END, junk_byte(), junk_ofs(), PACE_SPREAD);

		// Closing probes on the overflowed table: every offset bit set, zero, a
		// lookup that waits for a quiet unit, and a spare op code.
		queue_cmd(OP_QUERY, junk_byte(), '1, PACE_SPREAD);
		queue_cmd(OP_QUERY, junk_byte(), '0, PACE_SPREAD);
		queue_cmd(OP_QUERY, junk_byte(), pick_offset(), PACE_DRAIN);
		queue_cmd(OP_SPARE, junk_byte(), junk_ofs(), PACE_SPREAD);

		// Wind down: every command taken, every answer in, then a quiet spell in
		// which no stray result may appear.
		while (pending_cmds.size() != 0 || holding)
			@(negedge clk);
		while (awaited_answers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (awaited_answers.size() != 0)
			report_mismatch("answers never delivered", 64'(0),
				64'(awaited_answers.size()));

		$display("Run covered %0d source bytes (buffer %s), %0d end reports, %0d lookups",
			bytes_taken, bytes_seen[OFS_W] ? "filled to capacity" : "not full", ends_taken,
			lookups);
		$display("with %0d past the buffer end, %0d kept lines (overflow %s), %0d checked.",
			beyond, kept_lines, table_overflowed ? "reached" : "not reached",
			answers_checked);
		if (mismatch_count == 0) begin
			$display("line_index_builder_and_lookup_unit regression: pass");
		end else begin
			$display("line_index_builder_and_lookup_unit regression: fail");
		end
		$finish;
	end

	// Hard stop in case the unit hangs or stops answering.
	initial begin : watchdog
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("Timed out with %0d commands pending and %0d answers outstanding.",
			pending_cmds.size(), awaited_answers.size());
		$display("line_index_builder_and_lookup_unit regression: fail");
		$finish;
	end

endmodule
